### src/crdw_pkg.sv
// crdw_pkg: sizes, item and cache-entry types, and codes for the
// command replay/dedup window. No dependencies.
`default_nettype none

package crdw_pkg;

  // Window geometry and serial widths
  localparam int unsigned WINDOW     = 8;
  localparam int unsigned ID_BITS    = 16;
  localparam int unsigned RETRY_BITS = 8;
  localparam int unsigned IDX_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  // Request codes
  localparam logic [1:0] OP_CMD   = 2'd0;
  localparam logic [1:0] OP_OPEN  = 2'd1;
  localparam logic [1:0] OP_CLOSE = 2'd2;

  // Outcome codes
  localparam logic [2:0] OUT_NONE     = 3'd0;
  localparam logic [2:0] OUT_CLOSED   = 3'd1;
  localparam logic [2:0] OUT_ACC_NEW  = 3'd2;
  localparam logic [2:0] OUT_REJ_NEW  = 3'd3;
  localparam logic [2:0] OUT_REPLAY   = 3'd4;
  localparam logic [2:0] OUT_CONFLICT = 3'd5;
  localparam logic [2:0] OUT_RETRY    = 3'd6;
  localparam logic [2:0] OUT_STALE    = 3'd7;

  // Ack result and fault codes
  localparam logic       RES_ACCEPTED  = 1'b0;
  localparam logic       RES_REJECTED  = 1'b1;
  localparam logic [1:0] FLT_NONE      = 2'd0;
  localparam logic [1:0] FLT_DUPLICATE = 2'd1;
  localparam logic [1:0] FLT_MALFORMED = 2'd2;

  // Wire modes
  localparam logic [2:0] MODE_STOPPED = 3'd3;
  localparam logic [2:0] MODE_FAULTED = 3'd4;

  // Opcodes
  localparam logic [2:0] OPC_HOLD      = 3'd3;
  localparam logic [2:0] OPC_HEARTBEAT = 3'd4;

  // Dispatched events
  localparam logic [1:0] EVT_MOVE      = 2'd1;
  localparam logic [1:0] EVT_HOLD      = 2'd2;
  localparam logic [1:0] EVT_HEARTBEAT = 2'd3;

  // Watchdog activity
  localparam logic [2:0] ACT_NONE      = 3'd0;
  localparam logic [2:0] ACT_DUPLICATE = 3'd1;
  localparam logic [2:0] ACT_RETRY     = 3'd2;
  localparam logic [2:0] ACT_STALE     = 3'd3;
  localparam logic [2:0] ACT_VALID_NEW = 3'd4;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] cmd_id;
    logic [2:0]  opcode;
    logic [7:0]  retry_cnt;
    logic        frame_well_formed;
    logic        traffic_discarded;
    logic        machine_accepts;
    logic [2:0]  machine_mode;
  } in_item_t;

  typedef struct packed {
    logic        call_ok;
    logic [2:0]  outcome;
    logic        ack_valid;
    logic [15:0] ack_command_id;
    logic [2:0]  ack_opcode;
    logic [7:0]  ack_retry;
    logic        ack_result;
    logic [1:0]  ack_fault;
    logic [2:0]  ack_mode;
    logic [1:0]  event_kind;
    logic        raise_fault;
    logic [2:0]  activity;
  } out_item_t;

  // One cached acknowledgement
  typedef struct packed {
    logic [ID_BITS-1:0]    id;
    logic [2:0]            opcode;
    logic [RETRY_BITS-1:0] retry;
    logic                  result;
    logic [1:0]            fault;
    logic [2:0]            mode;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // Scan status handed from the window scanner to the controller
  typedef struct packed {
    logic             done;
    logic             hit;
    logic [IDX_W-1:0] idx;
  } scan_res_t;

endpackage

`default_nettype wire

### src/crdw_ram.sv
// crdw_ram: generic single-write, single-read RAM with registered read.
// No dependencies.
`default_nettype none

module crdw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                                         clk_i,
  input  wire logic                                         we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                             wdata_i,
  input  wire logic                                         re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output      logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### src/crdw_scan.sv
// crdw_scan: walks the cache RAM one entry per cycle looking for the first
// valid entry with a matching id. Depends on crdw_pkg.
`default_nettype none

module crdw_scan
  import crdw_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [ID_BITS-1:0] id_i,
  input  wire logic [WINDOW-1:0]  valid_i,
  input  wire entry_t             rd_data_i,
  output      logic               rd_en_o,
  output      logic [IDX_W-1:0]   rd_addr_o,
  output      scan_res_t          res_o,
  output      entry_t             hit_entry_o
);

  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(WINDOW - 1);

  logic             rd_act_q, cmp_vld_q, hit_q;
  logic [IDX_W-1:0] cnt_q, cmp_idx_q, hit_idx_q;
  entry_t           hit_entry_q;
  logic             match, done;

  // compare stage sees the entry read in the previous cycle
  assign match = cmp_vld_q && valid_i[cmp_idx_q] && (rd_data_i.id == id_i);
  assign done  = cmp_vld_q && (match || (cmp_idx_q == LastIdx));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_act_q  <= 1'b0;
      cmp_vld_q <= 1'b0;
      hit_q     <= 1'b0;
      cnt_q     <= '0;
      cmp_idx_q <= '0;
      hit_idx_q <= '0;
    end else if (start_i) begin
      rd_act_q  <= 1'b1;
      cmp_vld_q <= 1'b0;
      hit_q     <= 1'b0;
      cnt_q     <= '0;
    end else if (done) begin
      rd_act_q  <= 1'b0;
      cmp_vld_q <= 1'b0;
      hit_q     <= match;
      hit_idx_q <= cmp_idx_q;
    end else begin
      cmp_vld_q <= rd_act_q;
      cmp_idx_q <= cnt_q;
      if (rd_act_q) begin
        cnt_q    <= cnt_q + 1'b1;
        rd_act_q <= (cnt_q != LastIdx);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (match) begin
      hit_entry_q <= rd_data_i;
    end
  end

  assign rd_en_o     = rd_act_q;
  assign rd_addr_o   = cnt_q;
  assign res_o       = '{done: done, hit: hit_q, idx: hit_idx_q};
  assign hit_entry_o = hit_entry_q;

endmodule

`default_nettype wire

### src/command_replay_dedup_window_core.sv
// command_replay_dedup_window_core: top level of the command replay/dedup
// window. Depends on crdw_pkg, crdw_ram and crdw_scan.
//
//  Channel | Dir | Handshake              | Payload
//  --------+-----+------------------------+------------------------
//  in      | in  | in_valid_i / in_stall_o  | in_item_i  (in_item_t)
//  out     | out | out_valid_o / out_stall_i| out_item_o (out_item_t)
//
// Steps: a command frame in an open session takes an accept step, a scan
//   (one RAM read per window slot, early exit on the first hit) and a
//   finish step. Open, close, unknown, malformed and closed-session frames
//   skip the scan and go from accept straight to finish.
// Reset: asynchronous, clears the valid bits, write slot, last id, session
//   flag and all control state at once; RAM contents are only read behind
//   a valid bit, so no clearing pass is needed.
// Stalls: the result sits in an output register, so the next transfer is
//   taken while it waits; the finish step holds until that register is free.
`default_nettype none

module command_replay_dedup_window_core
  import crdw_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output      logic      in_stall_o,
  input  wire in_item_t  in_item_i,
  output      logic      out_valid_o,
  input  wire logic      out_stall_i,
  output      out_item_t out_item_o
);

  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(WINDOW - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_e;

  state_e state_q, state_d;

  // architectural state kept in flops; the entries live in the RAM
  logic [WINDOW-1:0]  valid_q, valid_d;
  logic [IDX_W-1:0]   wr_slot_q, wr_slot_d;
  logic               have_last_q, have_last_d;
  logic [ID_BITS-1:0] last_id_q, last_id_d;
  logic               session_q, session_d;

  in_item_t  in_q;
  out_item_t out_item_q, res;
  logic      out_valid_q, out_valid_d;

  logic in_xfer, fin_go, scan_start;

  // RAM / scanner wiring
  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  entry_t           ram_wdata, ram_rdata, hit_ent;
  scan_res_t        scan_res;

  // decode of the held item
  logic [ID_BITS-1:0]    id_c, delta;
  logic [RETRY_BITS-1:0] retry_c;
  logic                  fwd, stale, hist_clr, new_wr, rep_wr;
  logic [IDX_W-1:0]      new_slot;
  logic [2:0]            new_mode;

  assign id_c    = ID_BITS'(in_q.cmd_id);
  assign retry_c = RETRY_BITS'(in_q.retry_cnt);
  assign delta   = id_c - last_id_q;
  // forward serial: a cache hit is ignored and the frame counts as new
  assign fwd     = have_last_q && (delta != '0) && !delta[ID_BITS-1];
  assign stale   = have_last_q && ((delta == '0) || delta[ID_BITS-1]);

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign fin_go     = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);

  function automatic out_item_t put_ack(out_item_t o, logic [ID_BITS-1:0] id,
                                        logic [2:0] opc, logic [RETRY_BITS-1:0] rty,
                                        logic rs, logic [1:0] flt, logic [2:0] md);
    out_item_t r;
    r                = o;
    r.ack_valid      = 1'b1;
    r.ack_command_id = 16'(id);
    r.ack_opcode     = opc;
    r.ack_retry      = 8'(rty);
    r.ack_result     = rs;
    r.ack_fault      = flt;
    r.ack_mode       = md;
    return r;
  endfunction

  // finish step: decide the result and the state update
  always_comb begin
    res       = '0;
    hist_clr  = 1'b0;
    new_wr    = 1'b0;
    rep_wr    = 1'b0;
    session_d = session_q;
    new_mode  = (in_q.machine_mode <= MODE_STOPPED) ? in_q.machine_mode : MODE_FAULTED;
    case (in_q.op)
      OP_OPEN: begin
        if (!session_q && in_q.traffic_discarded) begin
          res.call_ok = 1'b1;
          hist_clr    = 1'b1;
          session_d   = 1'b1;
        end
      end
      OP_CLOSE: begin
        res.call_ok = 1'b1;
        hist_clr    = 1'b1;
        session_d   = 1'b0;
      end
      OP_CMD: begin
        if (in_q.frame_well_formed) begin
          res.call_ok = 1'b1;
          if (!session_q) begin
            res.outcome = OUT_CLOSED;
          end else if (scan_res.hit && !fwd) begin
            if (hit_ent.opcode != in_q.opcode) begin
              res = put_ack(res, id_c, in_q.opcode, retry_c, RES_REJECTED,
                            FLT_DUPLICATE, MODE_FAULTED);
              res.outcome     = OUT_CONFLICT;
              res.raise_fault = 1'b1;
              res.activity    = ACT_DUPLICATE;
            end else if (retry_c < hit_ent.retry) begin
              res = put_ack(res, id_c, in_q.opcode, retry_c, RES_REJECTED,
                            FLT_DUPLICATE, MODE_FAULTED);
              res.outcome     = OUT_RETRY;
              res.raise_fault = 1'b1;
              res.activity    = ACT_STALE;
            end else begin
              res = put_ack(res, id_c, in_q.opcode, retry_c, hit_ent.result,
                            hit_ent.fault, hit_ent.mode);
              res.outcome  = OUT_REPLAY;
              res.activity = (retry_c == hit_ent.retry) ? ACT_DUPLICATE : ACT_RETRY;
              rep_wr       = 1'b1;
            end
          end else if (stale) begin
            res = put_ack(res, id_c, in_q.opcode, retry_c, RES_REJECTED,
                          FLT_DUPLICATE, MODE_FAULTED);
            res.outcome     = OUT_STALE;
            res.raise_fault = 1'b1;
            res.activity    = ACT_STALE;
          end else begin
            // serial wrap empties the window before the new entry goes in
            hist_clr = have_last_q && (id_c < last_id_q);
            new_wr   = 1'b1;
            if (in_q.machine_accepts) begin
              res = put_ack(res, id_c, in_q.opcode, retry_c, RES_ACCEPTED,
                            FLT_NONE, new_mode);
              res.outcome = OUT_ACC_NEW;
            end else begin
              res = put_ack(res, id_c, in_q.opcode, retry_c, RES_REJECTED,
                            FLT_MALFORMED, MODE_FAULTED);
              res.outcome = OUT_REJ_NEW;
            end
            res.event_kind = (in_q.opcode == OPC_HOLD)      ? EVT_HOLD :
                             (in_q.opcode == OPC_HEARTBEAT) ? EVT_HEARTBEAT : EVT_MOVE;
            res.activity   = ACT_VALID_NEW;
          end
        end
      end
      default: ;
    endcase
  end

  // state update, committed only when the result is loaded
  always_comb begin
    valid_d     = valid_q;
    wr_slot_d   = wr_slot_q;
    have_last_d = have_last_q;
    last_id_d   = last_id_q;
    new_slot    = hist_clr ? '0 : wr_slot_q;
    if (fin_go && hist_clr) begin
      valid_d     = '0;
      wr_slot_d   = '0;
      have_last_d = 1'b0;
      last_id_d   = '0;
    end
    if (fin_go && new_wr) begin
      valid_d[new_slot] = 1'b1;
      wr_slot_d         = (new_slot == LastIdx) ? '0 : new_slot + 1'b1;
      have_last_d       = 1'b1;
      last_id_d         = id_c;
    end
  end

  // write-back: a new entry, or the hit entry with its retry count refreshed
  always_comb begin
    ram_we    = fin_go && (new_wr || rep_wr);
    ram_waddr = rep_wr ? scan_res.idx : new_slot;
    ram_wdata = hit_ent;
    if (rep_wr) begin
      ram_wdata.retry = retry_c;
    end else begin
      ram_wdata.id     = id_c;
      ram_wdata.opcode = in_q.opcode;
      ram_wdata.retry  = retry_c;
      ram_wdata.result = res.ack_result;
      ram_wdata.fault  = res.ack_fault;
      ram_wdata.mode   = res.ack_mode;
    end
  end

  // sequencer; a scan runs only for a good frame in an open session
  always_comb begin
    state_d    = state_q;
    scan_start = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if ((in_item_i.op == OP_CMD) && in_item_i.frame_well_formed && session_q) begin
            scan_start = 1'b1;
            state_d    = S_SCAN;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_SCAN: begin
        if (scan_res.done) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (fin_go) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (fin_go) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      wr_slot_q   <= '0;
      have_last_q <= 1'b0;
      last_id_q   <= '0;
      session_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      wr_slot_q   <= wr_slot_d;
      have_last_q <= have_last_d;
      last_id_q   <= last_id_d;
      if (fin_go) begin
        session_q <= session_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_q <= in_item_i;
    end
    if (fin_go) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // reads start in the cycle after the transfer; compares run on the registered RAM data against the held id
  crdw_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (scan_start),
    .id_i        (id_c),
    .valid_i     (valid_q),
    .rd_data_i   (ram_rdata),
    .rd_en_o     (ram_re),
    .rd_addr_o   (ram_raddr),
    .res_o       (scan_res),
    .hit_entry_o (hit_ent)
  );

  crdw_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (WINDOW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // scanner only reports while the sequencer waits for it
  a_scan_done_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_res.done |-> (state_q == S_SCAN))
    else $error("scan completion outside scan state");

  // write-back only in the finish step, so reads never overlap a write
  a_ram_wr_in_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_FIN))
    else $error("cache write outside finish step");

  // no last id means an empty window
  a_nolast_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !have_last_q |-> (valid_q == '0))
    else $error("cached entries without a last id");

  // a closed session holds no cached entries
  a_closed_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !session_q |-> (valid_q == '0))
    else $error("cached entries while session closed");

endmodule

`default_nettype wire

### dv/crdw_checker.sv
// crdw_checker: watches both channels of the command replay/dedup window,
// predicts each result from its own copy of the ack cache and compares.
// Depends on crdw_pkg.
`default_nettype none

module crdw_checker
  import crdw_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      in_stall_i,
  input  wire in_item_t  in_item_i,
  input  wire logic      out_valid_i,
  input  wire logic      out_stall_i,
  input  wire out_item_t out_item_i,
  output int             err_count_o,
  output int             acks_owed_o
);

  localparam logic [2:0]         OPC_RESERVED = 3'd6;
  localparam logic [ID_BITS-1:0] ID_HALF      = {1'b1, {(ID_BITS-1){1'b0}}};

  // shadow ack cache
  logic [WINDOW-1:0]  slot_used;
  entry_t             slot_q [WINDOW];
  logic [IDX_W-1:0]   wr_ptr;
  logic               have_last;
  logic [ID_BITS-1:0] last_id;
  logic               sess_open;

  out_item_t acks_owed [$];

  function automatic void forget_history();
    for (int i = 0; i < WINDOW; i++) begin
      slot_q[i]        = '0;
      slot_q[i].opcode = OPC_RESERVED;
    end
    slot_used = '0;
    wr_ptr    = '0;
    have_last = 1'b0;
    last_id   = '0;
  endfunction

  function automatic void mark_rejected(inout out_item_t r, input logic [2:0] outcome,
                                        input logic [2:0] act);
    r.outcome     = outcome;
    r.ack_result  = RES_REJECTED;
    r.ack_fault   = FLT_DUPLICATE;
    r.ack_mode    = MODE_FAULTED;
    r.raise_fault = 1'b1;
    r.activity    = act;
  endfunction

  // Returns the result for one request and advances the shadow state.
  function automatic out_item_t resolve_frame(input in_item_t req);
    out_item_t          r;
    logic [ID_BITS-1:0] id;
    logic [ID_BITS-1:0] delta;
    logic [2:0]         mode;
    int                 hit;
    r   = '0;
    hit = -1;
    id  = req.cmd_id[ID_BITS-1:0];
    case (req.op)
      OP_OPEN: begin
        if (!sess_open && req.traffic_discarded) begin
          forget_history();
          sess_open = 1'b1;
          r.call_ok = 1'b1;
        end
      end
      OP_CLOSE: begin
        forget_history();
        sess_open = 1'b0;
        r.call_ok = 1'b1;
      end
      OP_CMD: begin
        if (req.frame_well_formed) begin
          r.call_ok = 1'b1;
          if (!sess_open) begin
            r.outcome = OUT_CLOSED;
          end else begin
            delta = have_last ? id - last_id : ID_BITS'(1);
            for (int i = 0; i < WINDOW; i++) begin
              if (hit < 0 && slot_used[i] && slot_q[i].id == id) hit = i;
            end
            // a forward serial never replays, even on a cached id
            if (have_last && delta != '0 && delta < ID_HALF) hit = -1;
            r.ack_valid      = 1'b1;
            r.ack_command_id = req.cmd_id;
            r.ack_opcode     = req.opcode;
            r.ack_retry      = req.retry_cnt;
            if (hit >= 0) begin
              if (slot_q[hit].opcode != req.opcode) begin
                mark_rejected(r, OUT_CONFLICT, ACT_DUPLICATE);
              end else if (req.retry_cnt < slot_q[hit].retry) begin
                mark_rejected(r, OUT_RETRY, ACT_STALE);
              end else begin
                r.outcome    = OUT_REPLAY;
                r.ack_result = slot_q[hit].result;
                r.ack_fault  = slot_q[hit].fault;
                r.ack_mode   = slot_q[hit].mode;
                r.activity   = (req.retry_cnt == slot_q[hit].retry) ? ACT_DUPLICATE
                                                                    : ACT_RETRY;
                slot_q[hit].retry = req.retry_cnt;
              end
            end else if (have_last && (delta == '0 || delta >= ID_HALF)) begin
              mark_rejected(r, OUT_STALE, ACT_STALE);
            end else begin
              // serial wrap empties the cache before the write
              if (have_last && id < last_id) forget_history();
              if (req.machine_accepts) begin
                mode         = (req.machine_mode <= MODE_STOPPED) ? req.machine_mode
                                                                  : MODE_FAULTED;
                r.outcome    = OUT_ACC_NEW;
                r.ack_result = RES_ACCEPTED;
                r.ack_fault  = FLT_NONE;
                r.ack_mode   = mode;
              end else begin
                r.outcome    = OUT_REJ_NEW;
                r.ack_result = RES_REJECTED;
                r.ack_fault  = FLT_MALFORMED;
                r.ack_mode   = MODE_FAULTED;
              end
              r.event_kind = (req.opcode == OPC_HOLD)      ? EVT_HOLD :
                             (req.opcode == OPC_HEARTBEAT) ? EVT_HEARTBEAT : EVT_MOVE;
              r.activity   = ACT_VALID_NEW;
              slot_used[wr_ptr]     = 1'b1;
              slot_q[wr_ptr].id     = id;
              slot_q[wr_ptr].opcode = req.opcode;
              slot_q[wr_ptr].retry  = req.retry_cnt;
              slot_q[wr_ptr].result = r.ack_result;
              slot_q[wr_ptr].fault  = r.ack_fault;
              slot_q[wr_ptr].mode   = r.ack_mode;
              wr_ptr    = (wr_ptr == IDX_W'(WINDOW - 1)) ? '0 : wr_ptr + 1'b1;
              have_last = 1'b1;
              last_id   = id;
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      err_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      forget_history();
      sess_open = 1'b0;
      acks_owed.delete();
      err_count_o = 0;
      acks_owed_o = 0;
    end else begin
      // result side first: a transfer out at this edge is never the one
      // being accepted at the same edge
      if (out_valid_i && !out_stall_i) begin
        if (acks_owed.size() == 0) begin
          $error("result transfer with no request outstanding");
          err_count_o++;
        end else begin
          want = acks_owed.pop_front();
          check_field("call_ok",        16'(want.call_ok),     16'(out_item_i.call_ok));
          check_field("outcome",        16'(want.outcome),     16'(out_item_i.outcome));
          check_field("ack_valid",      16'(want.ack_valid),   16'(out_item_i.ack_valid));
          check_field("ack_command_id", want.ack_command_id,   out_item_i.ack_command_id);
          check_field("ack_opcode",     16'(want.ack_opcode),  16'(out_item_i.ack_opcode));
          check_field("ack_retry",      16'(want.ack_retry),   16'(out_item_i.ack_retry));
          check_field("ack_result",     16'(want.ack_result),  16'(out_item_i.ack_result));
          check_field("ack_fault",      16'(want.ack_fault),   16'(out_item_i.ack_fault));
          check_field("ack_mode",       16'(want.ack_mode),    16'(out_item_i.ack_mode));
          check_field("event_kind",     16'(want.event_kind),  16'(out_item_i.event_kind));
          check_field("raise_fault",    16'(want.raise_fault), 16'(out_item_i.raise_fault));
          check_field("activity",       16'(want.activity),    16'(out_item_i.activity));
        end
      end
      if (in_valid_i && !in_stall_i) acks_owed.push_back(resolve_frame(in_item_i));
      acks_owed_o = acks_owed.size();
    end
  end

endmodule

`default_nettype wire

### dv/tb_top.sv
// tb_top: stimulus and verdict for command_replay_dedup_window_core.
// Depends on crdw_pkg, the core RTL and crdw_checker (which does the result checking).
`default_nettype none

module tb_top;
  import crdw_pkg::*;

  // Request codes and field values the package does not name
  localparam logic [1:0] OP_UNKNOWN     = 2'd3;
  localparam logic [2:0] OPC_MOVE       = 3'd0;
  localparam logic [2:0] OPC_GRIP_OPEN  = 3'd1;
  localparam logic [2:0] OPC_GRIP_CLOSE = 3'd2;
  localparam logic [2:0] OPC_STOP       = 3'd5;
  localparam logic [2:0] OPC_RESERVED   = 3'd6;
  localparam logic [2:0] OPC_UNUSED     = 3'd7;
  localparam logic [2:0] MODE_IDLE      = 3'd0;
  localparam logic [2:0] MODE_MOVING    = 3'd1;
  localparam logic [2:0] MODE_RAW_TOP   = 3'd7;  // top raw mode, maps to faulted

  // ~800 transfers, with their idle and stall bursts, stay far below this
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_ITEMS  = 750;
  localparam int DRAIN_CYCLES  = 30;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_item_o;

  int err_count;
  int acks_owed;
  int cycle_cnt = 0;

  // quiet: no idling on either side while set
  logic quiet;

  // rough view of the session and recent ids, used only to aim stimulus
  logic        session_guess;
  logic [15:0] head_id;
  logic [15:0] recent_id    [8];
  logic [2:0]  recent_opc   [8];
  logic [7:0]  recent_retry [8];
  int          recent_n;
  int          recent_wr;

  command_replay_dedup_window_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  crdw_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_i  (out_item_o),
    .err_count_o (err_count),
    .acks_owed_o (acks_owed)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Hard stop if the block hangs
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL command_replay_dedup_window_core");
      $finish;
    end
  end

  // Result side backpressure: random stall bursts, off whenever quiet is set.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  function automatic in_item_t mk(input logic [1:0] op, input logic [15:0] id,
                                  input logic [2:0] opc, input logic [7:0] retry,
                                  input logic wf, input logic disc, input logic acc,
                                  input logic [2:0] mode);
    in_item_t it;
    it.op                = op;
    it.cmd_id            = id;
    it.opcode            = opc;
    it.retry_cnt         = retry;
    it.frame_well_formed = wf;
    it.traffic_discarded = disc;
    it.machine_accepts   = acc;
    it.machine_mode      = mode;
    return it;
  endfunction

  // One transfer in. Entered and left at a falling edge; an optional idle
  // burst drops valid first. Valid and payload hold until the edge where
  // stall is low.
  task automatic send_item(input in_item_t it);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Random request. Mostly well-formed frames in an open session: new ids
  // a few steps ahead, repeats of recent ids (replay, conflict, retry
  // regression), stale ids; the rest is malformed, unknown, open/close and
  // raw noise.
  task automatic send_random();
    in_item_t    it;
    logic [63:0] raw;
    int          pick;
    int          k;
    logic [15:0] step;
    if (!session_guess && $urandom_range(0, 3) != 0) begin
      send_item(mk(OP_OPEN, 16'($urandom), 3'($urandom), 8'($urandom), 1'($urandom),
                   1'b1, 1'($urandom), 3'($urandom)));
      session_guess = 1'b1;
      recent_n      = 0;
    end
    it.op                = OP_CMD;
    it.cmd_id            = head_id;
    it.opcode            = 3'($urandom_range(0, 7));
    it.retry_cnt         = 8'($urandom_range(0, 255));
    it.frame_well_formed = 1'b1;
    it.traffic_discarded = 1'($urandom_range(0, 1));
    it.machine_accepts   = ($urandom_range(0, 3) != 0);
    it.machine_mode      = 3'($urandom_range(0, 7));
    pick = $urandom_range(0, 99);
    if (pick < 28 && recent_n > 0) begin
      k = $urandom_range(0, recent_n - 1);
      it.cmd_id = recent_id[k];
      if ($urandom_range(0, 4) != 0) it.opcode = recent_opc[k];
      if ($urandom_range(0, 3) != 0) it.retry_cnt = 8'(recent_retry[k] + $urandom_range(0, 2));
      else it.retry_cnt = 8'(recent_retry[k] - $urandom_range(1, 3));
      if (it.opcode == recent_opc[k] && it.retry_cnt >= recent_retry[k])
        recent_retry[k] = it.retry_cnt;
    end else if (pick < 38) begin
      if ($urandom_range(0, 1) != 0) it.cmd_id = 16'(head_id - $urandom_range(1, 40));
      else it.cmd_id = 16'(head_id + 16'h8000 + $urandom_range(0, 64));
    end else if (pick < 44) begin
      it.frame_well_formed = 1'b0;
      it.cmd_id            = 16'($urandom);
    end else if (pick < 47) begin
      it.op     = OP_UNKNOWN;
      it.cmd_id = 16'($urandom);
    end else if (pick < 50) begin
      it.op = OP_CLOSE;
    end else if (pick < 53) begin
      it.op                = OP_OPEN;
      it.traffic_discarded = ($urandom_range(0, 3) != 0);
    end else if (pick < 56) begin
      raw = {$urandom, $urandom};
      it  = raw[$bits(in_item_t)-1:0];
    end else begin
      // new id: mostly small forward steps, some big jumps that wrap
      if (pick < 90) step = 16'($urandom_range(1, 6));
      else if (pick < 98) step = 16'($urandom_range(7, 16'h7fff));
      else step = 16'($urandom);
      head_id   = head_id + step;
      it.cmd_id = head_id;
      recent_id[recent_wr]    = head_id;
      recent_opc[recent_wr]   = it.opcode;
      recent_retry[recent_wr] = it.retry_cnt;
      recent_wr = (recent_wr + 1) % 8;
      if (recent_n < 8) recent_n++;
    end
    // follow session changes so the next items land in an open session
    if (it.op == OP_CLOSE) begin
      session_guess = 1'b0;
      recent_n      = 0;
    end else if (it.op == OP_OPEN && it.traffic_discarded && !session_guess) begin
      session_guess = 1'b1;
      recent_n      = 0;
    end
    send_item(it);
  endtask

  initial begin
    in_valid_i    = 1'b0;
    in_item_i     = '0;
    rst_ni        = 1'b0;
    quiet         = 1'b0;
    session_guess = 1'b0;
    head_id       = '0;
    recent_n      = 0;
    recent_wr     = 0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part: session rules, every outcome, wrap and serial edges
    send_item(mk(OP_CMD,   16'h0005, OPC_MOVE, 8'd0, 1'b1, 1'b0, 1'b1, MODE_IDLE));
    send_item(mk(OP_OPEN,  16'h0000, OPC_MOVE, 8'd0, 1'b1, 1'b0, 1'b1, MODE_IDLE));
    send_item(mk(OP_OPEN,  16'hffff, OPC_UNUSED, 8'hff, 1'b1, 1'b1, 1'b1, MODE_RAW_TOP));
    send_item(mk(OP_OPEN,  16'h0000, OPC_MOVE, 8'd0, 1'b1, 1'b1, 1'b1, MODE_IDLE));
    send_item(mk(OP_CMD,   16'h0010, OPC_MOVE, 8'd5, 1'b0, 1'b0, 1'b1, MODE_MOVING));
    send_item(mk(OP_UNKNOWN, 16'hffff, OPC_UNUSED, 8'hff, 1'b1, 1'b1, 1'b1, MODE_RAW_TOP));
    // new, then equal-retry replay, higher-retry replay, regression, conflict
    send_item(mk(OP_CMD,   16'h0010, OPC_MOVE, 8'd5, 1'b1, 1'b0, 1'b1, MODE_MOVING));
    send_item(mk(OP_CMD,   16'h0010, OPC_MOVE, 8'd5, 1'b1, 1'b0, 1'b0, MODE_IDLE));
    send_item(mk(OP_CMD,   16'h0010, OPC_MOVE, 8'd9, 1'b1, 1'b0, 1'b1, MODE_IDLE));
    send_item(mk(OP_CMD,   16'h0010, OPC_MOVE, 8'd3, 1'b1, 1'b0, 1'b1, MODE_IDLE));
    send_item(mk(OP_CMD,   16'h0010, OPC_GRIP_CLOSE, 8'd9, 1'b1, 1'b0, 1'b1, MODE_IDLE));
    // hold with out-of-range mode, heartbeat refused by the state machine
    send_item(mk(OP_CMD,   16'h0011, OPC_HOLD, 8'd0, 1'b1, 1'b0, 1'b1, MODE_RAW_TOP));
    send_item(mk(OP_CMD,   16'h0012, OPC_HEARTBEAT, 8'd1, 1'b1, 1'b0, 1'b0, MODE_STOPPED));
    // stale: older id with no cache hit, then delta of exactly half range
    send_item(mk(OP_CMD,   16'h0005, OPC_GRIP_OPEN, 8'd0, 1'b1, 1'b0, 1'b1, MODE_IDLE));
    send_item(mk(OP_CMD,   16'h8012, OPC_GRIP_OPEN, 8'd0, 1'b1, 1'b0, 1'b1, MODE_IDLE));
    // largest forward step, top of the id range, then a serial wrap
    send_item(mk(OP_CMD,   16'h8011, OPC_STOP, 8'hff, 1'b1, 1'b0, 1'b1, MODE_STOPPED));
    send_item(mk(OP_CMD,   16'hffff, OPC_UNUSED, 8'h00, 1'b1, 1'b0, 1'b1, MODE_MOVING));
    send_item(mk(OP_CMD,   16'h0001, OPC_RESERVED, 8'h80, 1'b1, 1'b0, 1'b1, MODE_IDLE));
    send_item(mk(OP_CMD,   16'h0010, OPC_MOVE, 8'd5, 1'b1, 1'b0, 1'b1, MODE_MOVING));
    // close, frame while closed, reopen
    send_item(mk(OP_CLOSE, 16'h0000, OPC_MOVE, 8'd0, 1'b0, 1'b0, 1'b0, MODE_IDLE));
    send_item(mk(OP_CMD,   16'h0010, OPC_MOVE, 8'd5, 1'b1, 1'b0, 1'b1, MODE_MOVING));
    send_item(mk(OP_OPEN,  16'h0000, OPC_MOVE, 8'd0, 1'b0, 1'b1, 1'b0, MODE_IDLE));
    send_item(mk(OP_CMD,   16'hffff, OPC_RESERVED, 8'h7f, 1'b1, 1'b1, 1'b1, MODE_IDLE));
    session_guess = 1'b1;
    head_id       = 16'hffff;

    // Random part; quiet stretch in the middle and at the end
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet = (n >= 650) || (n >= 300 && n < 360);
      send_random();
    end
    in_valid_i <= 1'b0;

    wait (acks_owed == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("PASS command_replay_dedup_window_core");
    end else begin
      $display("FAIL command_replay_dedup_window_core");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
src/crdw_pkg.sv
src/crdw_ram.sv
src/crdw_scan.sv
src/command_replay_dedup_window_core.sv
dv/crdw_checker.sv
dv/tb_top.sv
